### rtl/core/contrast_stretch_assert.svh
// Assertion macros shared by the contrast stretch RTL.
// Included by modules that carry concurrent checks; needs no package.
`ifndef CONTRAST_STRETCH_ASSERT_SVH
`define CONTRAST_STRETCH_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define CS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define CS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define CS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/core/cs_pkg.sv
// Package for the contrast stretch block: widths, lane count, codes, payload types.
// No dependencies; used by every other file of the block except the assertion header.
`timescale 1ns / 1ps

package cs_pkg;

   localparam int PIX_W       = 8;
   localparam int PIX_FIELDS  = 4;
   localparam int LANES       = 4;
   // lanes that take part, clipped to the packed group
   localparam int ACTIVE_LANES = (LANES < 1) ? 1 : ((LANES > PIX_FIELDS) ? PIX_FIELDS : LANES);
   localparam int GAIN_W      = 16;
   localparam logic [GAIN_W-1:0] GAIN_NUM = GAIN_W'(255 << 8);
   localparam int DIV_STEPS   = GAIN_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam logic [PIX_W-1:0] PIX_MAX = '1;

   localparam logic ACT_MEASURE = 1'b0;
   localparam logic ACT_SCALE   = 1'b1;
   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_SCALE  = 1'b1;

   typedef struct packed {
      logic             action;
      logic [PIX_W-1:0] pixel_a;
      logic [PIX_W-1:0] pixel_b;
      logic [PIX_W-1:0] pixel_c;
      logic [PIX_W-1:0] pixel_d;
      logic             frame_start;
      logic             frame_end;
   } req_payload_type;

   typedef struct packed {
      logic             kind;
      logic [PIX_W-1:0] scaled_a;
      logic [PIX_W-1:0] scaled_b;
      logic [PIX_W-1:0] scaled_c;
      logic [PIX_W-1:0] scaled_d;
      logic [PIX_W-1:0] frame_min;
      logic [PIX_W-1:0] frame_max;
   } rsp_payload_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### rtl/core/cs_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on cs_pkg for the payload types.
`timescale 1ns / 1ps

interface cs_req_if import cs_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface cs_rsp_if import cs_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/cs_lane.sv
// One stretch lane: clamped difference, gain multiply, registered, then saturate.
// Depends on cs_pkg.
`timescale 1ns / 1ps

module cs_lane import cs_pkg::*; (
   input  logic              clock,
   input  logic              load,
   input  logic [PIX_W-1:0]  pixel,
   input  logic [PIX_W-1:0]  run_min,
   input  logic [GAIN_W-1:0] gain,
   output logic [PIX_W-1:0]  scaled
);

   logic [PIX_W-1:0]        diff;
   logic [GAIN_W+PIX_W-1:0] product;
   logic [GAIN_W-1:0]       prod_ff;
   logic [GAIN_W-1:0]       prod_in;

   // drop pixels at or below the minimum to zero
   assign diff    = (pixel > run_min) ? (pixel - run_min) : '0;
   assign product = (GAIN_W+PIX_W)'(gain) * (GAIN_W+PIX_W)'(diff);
   assign prod_in = product[GAIN_W+PIX_W-1:PIX_W];

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign scaled = (prod_ff > GAIN_W'(PIX_MAX)) ? PIX_MAX : prod_ff[PIX_W-1:0];

endmodule

### rtl/core/cs_merge.sv
// Merging stage: folds the active lanes' pixels into the running min and max.
// Depends on cs_pkg.
`timescale 1ns / 1ps

module cs_merge import cs_pkg::*; (
   input  logic [PIX_W-1:0] pixels [ACTIVE_LANES],
   input  logic [PIX_W-1:0] run_min,
   input  logic [PIX_W-1:0] run_max,
   input  logic             restart,
   output logic [PIX_W-1:0] new_min,
   output logic [PIX_W-1:0] new_max
);

   always_comb begin
      logic [PIX_W-1:0] lo;
      logic [PIX_W-1:0] hi;
      lo = restart ? PIX_MAX : run_min;
      hi = restart ? '0 : run_max;
      for (int i = 0; i < ACTIVE_LANES; i++) begin
         if (pixels[i] < lo) lo = pixels[i];
         if (pixels[i] > hi) hi = pixels[i];
      end
      new_min = lo;
      new_max = hi;
   end

endmodule

### rtl/core/cs_div.sv
// Restoring divider for the gain: constant numerator over an 8-bit span, one bit per cycle.
// Depends on cs_pkg.
`timescale 1ns / 1ps

module cs_div import cs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PIX_W-1:0]  divisor,
   output div_status_type    status,
   output logic [GAIN_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [GAIN_W-1:0]    quo_ff, quo_in;
   logic [PIX_W-1:0]     rem_ff, rem_in;
   logic [PIX_W-1:0]     dvs_ff, dvs_in;
   logic [PIX_W:0]       rem_sh;

   assign rem_sh = {rem_ff, quo_ff[GAIN_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = GAIN_NUM;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // shift in the next numerator bit, subtract when it fits
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = PIX_W'(rem_sh - {1'b0, dvs_ff});
            quo_in = {quo_ff[GAIN_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[PIX_W-1:0];
            quo_in = {quo_ff[GAIN_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

### rtl/core/contrast_stretch.sv
// contrast_stretch: min/max contrast stretch on four packed 8-bit pixels per transaction.
// Measure transaction without frame end: updates the running min/max, one per cycle while idle, no response.
// Scale transaction: lane results registered on acceptance, response registered in ST_EMIT once output is free.
// Frame-end measure: restoring divide for the gain in ST_DIV, then the report is registered in ST_EMIT.
// A flat frame skips the divide (gain 0) and goes straight to ST_EMIT.
// Synchronous reset: min 255, max 0, gain 0, no response pending.
`timescale 1ns / 1ps
`include "contrast_stretch_assert.svh"

module contrast_stretch import cs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   cs_req_if.sink   req_chan,
   cs_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type         state_ff;
   logic [PIX_W-1:0]  run_min_ff;
   logic [PIX_W-1:0]  run_max_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic              pend_kind_ff;
   logic              rsp_valid_ff;
   rsp_payload_type   rsp_data_ff;

   req_payload_type   req;
   logic              accept;
   logic              is_measure;
   logic              out_free;
   logic [PIX_W-1:0]  req_pix [PIX_FIELDS];
   logic [PIX_W-1:0]  act_pix [ACTIVE_LANES];
   logic [PIX_W-1:0]  lane_out [PIX_FIELDS];
   logic [PIX_W-1:0]  mrg_min;
   logic [PIX_W-1:0]  mrg_max;
   logic              div_start;
   logic [PIX_W-1:0]  div_divisor;
   div_status_type    div_stat;
   logic [GAIN_W-1:0] div_quo;
   logic              lane_load;
   rsp_payload_type   emit_data;

   // Input side: take a transaction only when no earlier one is still at work.
   assign req            = req_chan.payload;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_measure     = (req.action == ACT_MEASURE);

   assign req_pix[0] = req.pixel_a;
   assign req_pix[1] = req.pixel_b;
   assign req_pix[2] = req.pixel_c;
   assign req_pix[3] = req.pixel_d;

   // Lanes: one stretch unit per active pixel; unused lanes read as zero.
   assign lane_load = accept && !is_measure;

   for (genvar i = 0; i < PIX_FIELDS; i++) begin : g_lane
      if (i < ACTIVE_LANES) begin : g_on
         assign act_pix[i] = req_pix[i];
         cs_lane u_lane (
            .clock   (clock),
            .load    (lane_load),
            .pixel   (req_pix[i]),
            .run_min (run_min_ff),
            .gain    (gain_ff),
            .scaled  (lane_out[i])
         );
      end else begin : g_off
         assign lane_out[i] = '0;
      end
   end

   // Merge the lanes' pixels into the running extremes.
   cs_merge u_merge (
      .pixels  (act_pix),
      .run_min (run_min_ff),
      .run_max (run_max_ff),
      .restart (req.frame_start),
      .new_min (mrg_min),
      .new_max (mrg_max)
   );

   // Gain divide starts on an accepted frame-end measure whose span is nonzero.
   assign div_divisor = mrg_max - mrg_min;
   assign div_start   = accept && is_measure && req.frame_end && (mrg_max > mrg_min);

   cs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (div_divisor),
      .status   (div_stat),
      .quotient (div_quo)
   );

   // Response assembly: a report carries zero pixels.
   always_comb begin
      emit_data.kind      = pend_kind_ff;
      emit_data.scaled_a  = (pend_kind_ff == KIND_SCALE) ? lane_out[0] : '0;
      emit_data.scaled_b  = (pend_kind_ff == KIND_SCALE) ? lane_out[1] : '0;
      emit_data.scaled_c  = (pend_kind_ff == KIND_SCALE) ? lane_out[2] : '0;
      emit_data.scaled_d  = (pend_kind_ff == KIND_SCALE) ? lane_out[3] : '0;
      emit_data.frame_min = run_min_ff;
      emit_data.frame_max = run_max_ff;
   end

   // Output register is free when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_min_ff   <= PIX_MAX;
         run_max_ff   <= '0;
         gain_ff      <= '0;
         pend_kind_ff <= KIND_REPORT;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the held response once taken, unless a new one replaces it
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (is_measure) begin
                     run_min_ff <= mrg_min;
                     run_max_ff <= mrg_max;
                     if (req.frame_end) begin
                        pend_kind_ff <= KIND_REPORT;
                        if (mrg_max > mrg_min) begin
                           state_ff <= ST_DIV;
                        end else begin
                           // flat frame: no divide, gain is zero
                           gain_ff  <= '0;
                           state_ff <= ST_EMIT;
                        end
                     end
                  end else begin
                     pend_kind_ff <= KIND_SCALE;
                     state_ff     <= ST_EMIT;
                  end
               end
            end
            ST_DIV: begin
               if (div_stat.done) begin
                  gain_ff  <= div_quo;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               // hold until the output register can take the response
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
      if (state_ff == ST_EMIT && out_free) begin
         rsp_data_ff <= emit_data;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // Checks
   `CS_ASSERT_IMPL(a_div_span_nonzero, clock, reset, div_start, div_divisor != '0)
   `CS_ASSERT_NEXT(a_min_held_busy, clock, reset, state_ff != ST_IDLE, $stable(run_min_ff))
   `CS_ASSERT_NEXT(a_max_held_busy, clock, reset, state_ff != ST_IDLE, $stable(run_max_ff))
   `CS_ASSERT_IMPL(a_div_only_in_div, clock, reset, div_stat.done, state_ff == ST_DIV)
   `CS_ASSERT_IMPL(a_report_zero_pix, clock, reset, rsp_valid_ff && (rsp_data_ff.kind == KIND_REPORT), (rsp_data_ff.scaled_a == '0) && (rsp_data_ff.scaled_d == '0))

endmodule
